### hw/rtl/vscf_pkg.sv
// ----------------------------------------------------------------------------
// vscf_pkg
// Shared types and constants for the voxel shape charge fill block.
// ----------------------------------------------------------------------------
package vscf_pkg;

  localparam int GRID_SIZE_DEF = 64;

  localparam int CNT_W = 19;
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // shape_mode codes
  localparam logic [1:0] MODE_BOX = 2'd0;
  localparam logic [1:0] MODE_CYL = 2'd1;
  localparam logic [1:0] MODE_ELL = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_SHAPE_MODE = 3'd0;
  localparam logic [2:0] REG_CENTER_X   = 3'd1;
  localparam logic [2:0] REG_CENTER_Y   = 3'd2;
  localparam logic [2:0] REG_CENTER_Z   = 3'd3;
  localparam logic [2:0] REG_SEMI_A     = 3'd4;
  localparam logic [2:0] REG_SEMI_B     = 3'd5;
  localparam logic [2:0] REG_SEMI_C     = 3'd6;
  localparam logic [2:0] REG_CHARGE     = 3'd7;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] cx;
    logic [15:0] cy;
    logic [15:0] cz;
    logic [14:0] sa;
    logic [14:0] sb;
    logic [14:0] sc;
  } shape_cfg_t;

  typedef struct packed {
    logic busy;
    logic hit;
  } shape_stat_t;

  typedef struct packed {
    logic             start;
    logic [31:0]      dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic [31:0] quotient;
  } div_stat_t;

  typedef enum logic [0:0] {ST_IDLE, ST_WAIT} top_state_t;

  typedef enum logic [1:0] {SH_IDLE, SH_MUL, SH_CMP} shape_state_t;

  typedef enum logic [0:0] {DV_IDLE, DV_RUN} div_state_t;

  // multiplier micro-steps of the shape test, in issue order
  typedef enum logic [4:0] {
    MS_A2, MS_B2, MS_C2, MS_X2, MS_Y2, MS_Z2,
    MS_U, MS_V, MS_W,
    MS_UC_LO, MS_UC_HI, MS_VC_LO, MS_VC_HI,
    MS_WZ_LO, MS_WZ_HI, MS_WC_LO, MS_WC_HI
  } mstep_t;

endpackage

### hw/rtl/voxel_shape_charge_fill_top.sv
// ----------------------------------------------------------------------------
// voxel_shape_charge_fill_top
// Voxel-in-solid test with inside counting and per-voxel charge density.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. Each voxel index is tested against a box,
// an elliptic cylinder (axis along z) or an ellipsoid, in Q8.8 grid units,
// by cross-multiplied comparisons on a single shared 30x30 multiplier that
// a small sequencer drives one product a cycle. In the counting pass the
// running inside count is bumped (saturating); in the fill pass an inside
// voxel gets charge_per_cell over that count from a one-bit-a-cycle
// divider that runs alongside the shape test. The block takes one voxel at
// a time: the next beat is taken once the shape test is done (a box or a
// voxel rejected by the per-axis check skips the multiplier, a cylinder runs
// its steps up to MS_W, an ellipsoid all of them) and, for a fill-pass voxel
// with a non-zero count, the 32 divider steps. A finished result sits in the
// output register, so the next voxel is taken while the previous beat still
// waits downstream. restart_count clears the count before its own voxel.
// Configuration must be written only while idle (not enforced by the block).
// ----------------------------------------------------------------------------
module voxel_shape_charge_fill_top
  import vscf_pkg::*;
#(
  parameter int GRID_SIZE = GRID_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input voxel beats
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // vox_x[5:0], vox_y[11:6], vox_z[17:12], zero pad
  input  logic [1:0]  s_tuser,   // fill_pass[0], restart_count[1]
  // result beats
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // inside_res[0], points_so_far[19:1],
                                 // density[51:20], empty_shape[52], zero pad
  // configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // configuration registers
  shape_cfg_t  cfg;
  logic [31:0] charge;

  top_state_t       state, state_next;
  logic             fill;
  logic [CNT_W-1:0] inside_count, cnt_eff, cnt_next;
  logic             s_acc, fin;
  logic             out_inside, out_empty;
  logic [31:0]      out_density;

  shape_stat_t shape_st;
  div_req_t    div_rq;
  div_stat_t   div_st;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode <= MODE_BOX;
      cfg.cx   <= '0;
      cfg.cy   <= '0;
      cfg.cz   <= '0;
      cfg.sa   <= 15'd256;
      cfg.sb   <= 15'd256;
      cfg.sc   <= 15'd256;
      charge   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SHAPE_MODE: cfg.mode <= cfg_data[1:0];
        REG_CENTER_X:   cfg.cx   <= cfg_data[15:0];
        REG_CENTER_Y:   cfg.cy   <= cfg_data[15:0];
        REG_CENTER_Z:   cfg.cz   <= cfg_data[15:0];
        REG_SEMI_A:     cfg.sa   <= cfg_data[14:0];
        REG_SEMI_B:     cfg.sb   <= cfg_data[14:0];
        REG_SEMI_C:     cfg.sc   <= cfg_data[14:0];
        REG_CHARGE:     charge   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign s_acc    = s_tvalid && s_tready;
  // count as seen by this voxel, after an optional restart
  assign cnt_eff  = s_tuser[1] ? '0 : inside_count;

  // both engines done and the output register free
  assign fin = !shape_st.busy && !div_st.busy && (!m_tvalid || m_tready);

  vscf_shape #(
    .GRID_SIZE(GRID_SIZE)
  ) u_shape (
    .clk   (clk),
    .rst   (rst),
    .start (s_acc),
    .vox_x (s_tdata[5:0]),
    .vox_y (s_tdata[11:6]),
    .vox_z (s_tdata[17:12]),
    .cfg   (cfg),
    .stat  (shape_st)
  );

  always_comb begin
    div_rq.start    = s_acc && s_tuser[0] && (cnt_eff != '0);
    div_rq.dividend = charge;
    div_rq.divisor  = cnt_eff;
  end

  vscf_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_rq),
    .stat (div_st)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (s_acc) begin
        state_next = ST_WAIT;
      end
      ST_WAIT: if (fin) begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // result of the voxel in flight
  always_comb begin
    out_inside  = shape_st.hit;
    cnt_next    = inside_count;
    out_empty   = 1'b0;
    out_density = '0;
    if (!fill) begin
      if (out_inside && (inside_count != COUNT_MAX)) begin
        cnt_next = inside_count + 1'b1;
      end
    end else if (inside_count == '0) begin
      out_empty = 1'b1;
    end else if (out_inside) begin
      out_density = div_st.quotient;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_count <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (s_acc) begin
        inside_count <= cnt_eff;
      end else if (state == ST_WAIT && fin) begin
        inside_count <= cnt_next;
      end
      if (state == ST_WAIT && fin) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      fill <= s_tuser[0];
    end
    if (state == ST_WAIT && fin) begin
      m_tdata <= {3'b0, out_empty, out_density, cnt_next, out_inside};
    end
  end

  // no new voxel while either engine is still working
  a_idle_engines: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (!shape_st.busy && !div_st.busy))
    else $error("input ready while an engine is busy");

  // the count only steps up by one or restarts
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (inside_count != $past(inside_count)) |->
      ((inside_count == '0) || (inside_count == $past(inside_count) + 1'b1)))
    else $error("inside count jumped");

  // an empty-shape beat carries no density and a zero count
  a_empty_beat: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[52]) |-> ((m_tdata[51:20] == '0) && (m_tdata[19:1] == '0)))
    else $error("empty shape beat with density or count");

endmodule

### hw/rtl/vscf_shape.sv
// ----------------------------------------------------------------------------
// vscf_shape
// Inside test for box, elliptic cylinder and ellipsoid on one shared 30x30
// multiplier, sequenced one product a cycle with registered write-back.
// ----------------------------------------------------------------------------
module vscf_shape
  import vscf_pkg::*;
#(
  parameter int GRID_SIZE = GRID_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [5:0]  vox_x,
  input  logic [5:0]  vox_y,
  input  logic [5:0]  vox_z,
  input  shape_cfg_t  cfg,
  output shape_stat_t stat
);

  localparam logic [8:0] GRID_LIM = 9'(GRID_SIZE);

  shape_state_t state, state_next;
  mstep_t       step, wb_step, last_step;
  logic         issuing, wb_valid;
  logic [59:0]  prod, mul_p;
  logic [29:0]  mul_a, mul_b;
  logic [14:0]  dx, dy, dz;
  logic         pre_ok, hit;
  logic [29:0]  a2, b2, c2, x2, y2, z2;
  logic [59:0]  u, v, w;
  logic [91:0]  lhs, rhs, addend, acc_base, acc_sum;
  logic         acc_hi, acc_rhs, acc_en;
  logic [16:0]  mx, my, mz;
  logic         on_grid, mode_ok, in_axes, pre_ok_in, need_mul;
  logic         cyl_le, ell_le;

  // |vox*256 - centre|
  function automatic logic [16:0] off_mag(input logic [5:0] vx, input logic [15:0] c);
    logic signed [17:0] d;
    d = $signed({4'b0, vx, 8'b0}) - $signed({{2{c[15]}}, c});
    off_mag = d[17] ? 17'(-d) : d[16:0];
  endfunction

  always_comb begin
    mx        = off_mag(vox_x, cfg.cx);
    my        = off_mag(vox_y, cfg.cy);
    mz        = off_mag(vox_z, cfg.cz);
    on_grid   = ({3'b0, vox_x} < GRID_LIM) && ({3'b0, vox_y} < GRID_LIM) &&
                ({3'b0, vox_z} < GRID_LIM);
    mode_ok   = (cfg.mode == MODE_BOX) || (cfg.mode == MODE_CYL) ||
                (cfg.mode == MODE_ELL);
    in_axes   = (mx <= {2'b0, cfg.sa}) && (my <= {2'b0, cfg.sb}) &&
                (mz <= {2'b0, cfg.sc});
    pre_ok_in = on_grid && mode_ok && in_axes;
    need_mul  = pre_ok_in && (cfg.mode != MODE_BOX);
    last_step = (cfg.mode == MODE_CYL) ? MS_W : MS_WC_HI;
  end

  // operand select
  always_comb begin
    case (step)
      MS_A2:    begin mul_a = {15'b0, cfg.sa}; mul_b = {15'b0, cfg.sa}; end
      MS_B2:    begin mul_a = {15'b0, cfg.sb}; mul_b = {15'b0, cfg.sb}; end
      MS_C2:    begin mul_a = {15'b0, cfg.sc}; mul_b = {15'b0, cfg.sc}; end
      MS_X2:    begin mul_a = {15'b0, dx};     mul_b = {15'b0, dx};     end
      MS_Y2:    begin mul_a = {15'b0, dy};     mul_b = {15'b0, dy};     end
      MS_Z2:    begin mul_a = {15'b0, dz};     mul_b = {15'b0, dz};     end
      MS_U:     begin mul_a = x2;              mul_b = b2;              end
      MS_V:     begin mul_a = y2;              mul_b = a2;              end
      MS_W:     begin mul_a = a2;              mul_b = b2;              end
      MS_UC_LO: begin mul_a = u[29:0];         mul_b = c2;              end
      MS_UC_HI: begin mul_a = u[59:30];        mul_b = c2;              end
      MS_VC_LO: begin mul_a = v[29:0];         mul_b = c2;              end
      MS_VC_HI: begin mul_a = v[59:30];        mul_b = c2;              end
      MS_WZ_LO: begin mul_a = w[29:0];         mul_b = z2;              end
      MS_WZ_HI: begin mul_a = w[59:30];        mul_b = z2;              end
      MS_WC_LO: begin mul_a = w[29:0];         mul_b = c2;              end
      MS_WC_HI: begin mul_a = w[59:30];        mul_b = c2;              end
      default:  begin mul_a = '0;              mul_b = '0;              end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // accumulator for the ellipsoid sums
  always_comb begin
    acc_en   = wb_valid && (wb_step inside {MS_UC_LO, MS_UC_HI, MS_VC_LO, MS_VC_HI,
                                            MS_WZ_LO, MS_WZ_HI, MS_WC_LO, MS_WC_HI});
    acc_hi   = wb_step inside {MS_UC_HI, MS_VC_HI, MS_WZ_HI, MS_WC_HI};
    acc_rhs  = wb_step inside {MS_WC_LO, MS_WC_HI};
    addend   = acc_hi ? {2'b0, prod, 30'b0} : {32'b0, prod};
    acc_base = acc_rhs ? rhs : lhs;
    acc_sum  = acc_base + addend;
  end

  assign cyl_le = ({1'b0, u} + {1'b0, v}) <= {1'b0, w};
  assign ell_le = lhs <= rhs;

  always_comb begin
    state_next = state;
    case (state)
      SH_IDLE: if (start) begin
        state_next = need_mul ? SH_MUL : SH_CMP;
      end
      SH_MUL:  if (!issuing && wb_valid) begin
        state_next = SH_CMP;
      end
      SH_CMP:  state_next = SH_IDLE;
      default: state_next = SH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SH_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing  <= 1'b0;
      wb_valid <= 1'b0;
    end else if (state == SH_IDLE) begin
      issuing  <= start && need_mul;
      wb_valid <= 1'b0;
    end else if (state == SH_MUL) begin
      wb_valid <= issuing;
      if (issuing && (step == last_step)) begin
        issuing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == SH_IDLE && start) begin
      dx     <= mx[14:0];
      dy     <= my[14:0];
      dz     <= mz[14:0];
      pre_ok <= pre_ok_in;
      step   <= MS_A2;
      lhs    <= '0;
      rhs    <= '0;
    end
    if (state == SH_MUL && issuing) begin
      prod    <= mul_p;
      wb_step <= step;
      if (step != last_step) begin
        step <= mstep_t'(step + 5'd1);
      end
    end
    if (state == SH_MUL && wb_valid) begin
      case (wb_step)
        MS_A2:   a2 <= prod[29:0];
        MS_B2:   b2 <= prod[29:0];
        MS_C2:   c2 <= prod[29:0];
        MS_X2:   x2 <= prod[29:0];
        MS_Y2:   y2 <= prod[29:0];
        MS_Z2:   z2 <= prod[29:0];
        MS_U:    u  <= prod;
        MS_V:    v  <= prod;
        MS_W:    w  <= prod;
        default: ;
      endcase
      if (acc_en) begin
        if (acc_rhs) begin
          rhs <= acc_sum;
        end else begin
          lhs <= acc_sum;
        end
      end
    end
    if (state == SH_CMP) begin
      hit <= pre_ok && ((cfg.mode == MODE_BOX) ||
                        ((cfg.mode == MODE_CYL) && cyl_le) ||
                        ((cfg.mode == MODE_ELL) && ell_le));
    end
  end

  assign stat.busy = (state != SH_IDLE);
  assign stat.hit  = hit;

endmodule

### hw/rtl/vscf_div.sv
// ----------------------------------------------------------------------------
// vscf_div
// Restoring divider, signed 32-bit dividend over a non-zero unsigned count,
// one quotient bit a cycle, truncated toward zero.
// ----------------------------------------------------------------------------
module vscf_div
  import vscf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  div_req_t  req,
  output div_stat_t stat
);

  div_state_t       state, state_next;
  logic [4:0]       cnt;
  logic [CNT_W-1:0] rem, dsr;
  logic [31:0]      quo;
  logic             neg;
  logic [CNT_W:0]   r_sh;
  logic [CNT_W+1:0] diff;
  logic             ge;

  assign r_sh = {rem, quo[31]};
  assign diff = {1'b0, r_sh} - {2'b0, dsr};
  assign ge   = !diff[CNT_W+1];

  always_comb begin
    state_next = state;
    case (state)
      DV_IDLE: if (req.start) begin
        state_next = DV_RUN;
      end
      DV_RUN:  if (cnt == 5'd0) begin
        state_next = DV_IDLE;
      end
      default: state_next = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == DV_IDLE && req.start) begin
      neg <= req.dividend[31];
      quo <= req.dividend[31] ? -req.dividend : req.dividend;
      rem <= '0;
      dsr <= req.divisor;
      cnt <= 5'd31;
    end else if (state == DV_RUN) begin
      rem <= ge ? diff[CNT_W-1:0] : r_sh[CNT_W-1:0];
      quo <= {quo[30:0], ge};
      cnt <= cnt - 5'd1;
    end
  end

  assign stat.busy     = (state != DV_IDLE);
  assign stat.quotient = neg ? -quo : quo;

endmodule
